FILE: src/rs485_frame_builder_top_defines.svh
// ----------------------------------------------------------------------------
// rs485 frame builder assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef RS485_FRAME_BUILDER_TOP_DEFINES_SVH
`define RS485_FRAME_BUILDER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RSFB_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define RSFB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rsfb_pkg.sv
// ----------------------------------------------------------------------------
// rsfb_pkg
// shared types and constants of the rs485 frame builder
// ----------------------------------------------------------------------------
package rsfb_pkg;

    localparam logic [7:0] PREAMBLE_0 = 8'hFF;
    localparam logic [7:0] PREAMBLE_1 = 8'h00;
    localparam logic [7:0] PREAMBLE_2 = 8'hFF;
    localparam logic [7:0] PREAMBLE_3 = 8'hA5;

    localparam logic CMD_HEADER  = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    // job kinds handed from front to back
    localparam logic [1:0] KIND_HDR  = 2'd0;   // preamble + header (+ checksum if empty)
    localparam logic [1:0] KIND_PAY  = 2'd1;   // one payload byte
    localparam logic [1:0] KIND_PEND = 2'd2;   // last payload byte + checksum
    localparam logic [1:0] KIND_ERR  = 2'd3;   // payload with no open frame

    // emission steps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_PRE0    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_PRE1    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_PRE2    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_PRE3    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_PROTO   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_DEST    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_SRC     = 4'd6;
    localparam logic [STEP_W-1:0] STEP_MSG     = 4'd7;
    localparam logic [STEP_W-1:0] STEP_LEN     = 4'd8;
    localparam logic [STEP_W-1:0] STEP_HCSUM_H = 4'd9;
    localparam logic [STEP_W-1:0] STEP_HCSUM_L = 4'd10;
    localparam logic [STEP_W-1:0] STEP_DATA    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_PCSUM_H = 4'd1;
    localparam logic [STEP_W-1:0] STEP_PCSUM_L = 4'd2;

    // job queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  protocol_id;
        logic [7:0]  destination;
        logic [7:0]  source;
        logic [7:0]  message_code;
        logic [7:0]  payload_length;
        logic [7:0]  data;
        logic [15:0] csum;
    } job_t;

endpackage

FILE: src/rs485_frame_builder_top.sv
// ----------------------------------------------------------------------------
// rs485_frame_builder_top
// an accepted item passes the job queue, then the sequencer's job and output registers
// throughput: one beat per cycle unless stalled; headers give 9 or 11 beats, payload 1 or 3
// input takes one item per cycle while the 4-entry job queue has room
// reset: synchronous active-low aresetn clears frame state, queue and output
// ----------------------------------------------------------------------------
module rs485_frame_builder_top
    import rsfb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // input channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    input  logic [7:0] s_protocol_id,
    input  logic [7:0] s_destination,
    input  logic [7:0] s_source,
    input  logic [7:0] s_message_code,
    input  logic [7:0] s_payload_length,
    input  logic [7:0] s_payload_byte,
    // result channel, one frame byte per beat
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_tx_byte,
    output logic       m_frame_end,
    output logic       m_seq_last,
    output logic       m_error
);

    // front to queue
    logic q_push;
    logic q_full;
    job_t q_in_job;

    // queue to back
    logic q_pop;
    logic q_head_valid;
    job_t q_head_job;

    // front: classifies items, keeps running sum and byte count, one job per item
    rsfb_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_protocol_id    (s_protocol_id),
        .s_destination    (s_destination),
        .s_source         (s_source),
        .s_message_code   (s_message_code),
        .s_payload_length (s_payload_length),
        .s_payload_byte   (s_payload_byte),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_job            (q_in_job)
    );

    // job queue decouples the front from the byte sequencer
    rsfb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_in_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    // back: walks each job one byte per beat into the output register
    rsfb_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_head_valid),
        .q_job       (q_head_job),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_tx_byte   (m_tx_byte),
        .m_frame_end (m_frame_end),
        .m_seq_last  (m_seq_last),
        .m_error     (m_error)
    );

endmodule

FILE: src/rsfb_front.sv
// ----------------------------------------------------------------------------
// rsfb_front
// accepts items, tracks frame state and checksum, emits jobs
// ----------------------------------------------------------------------------
module rsfb_front
    import rsfb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    input  logic [7:0] s_protocol_id,
    input  logic [7:0] s_destination,
    input  logic [7:0] s_source,
    input  logic [7:0] s_message_code,
    input  logic [7:0] s_payload_length,
    input  logic [7:0] s_payload_byte,
    input  logic       q_full,
    output logic       q_push,
    output job_t       q_job
);

    logic [15:0] sum_reg,  sum_next;
    logic [7:0]  left_reg, left_next;
    logic        open_reg, open_next;
    logic [15:0] hdr_sum;
    logic [15:0] pay_sum;
    logic [7:0]  pay_left;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    assign hdr_sum = 16'(PREAMBLE_3) + 16'(s_protocol_id) + 16'(s_destination)
                   + 16'(s_source) + 16'(s_message_code) + 16'(s_payload_length);
    assign pay_sum  = sum_reg + 16'(s_payload_byte);
    assign pay_left = left_reg - 8'd1;

    always_comb begin
        sum_next             = sum_reg;
        left_next            = left_reg;
        open_next            = open_reg;
        q_job.kind           = KIND_ERR;
        q_job.protocol_id    = s_protocol_id;
        q_job.destination    = s_destination;
        q_job.source         = s_source;
        q_job.message_code   = s_message_code;
        q_job.payload_length = s_payload_length;
        q_job.data           = s_payload_byte;
        q_job.csum           = hdr_sum;
        if (s_command == CMD_HEADER) begin
            q_job.kind = KIND_HDR;
            if (s_payload_length == 8'd0) begin
                // empty frame closes inside the header job
                sum_next  = '0;
                left_next = '0;
                open_next = 1'b0;
            end else begin
                sum_next  = hdr_sum;
                left_next = s_payload_length;
                open_next = 1'b1;
            end
        end else if (!open_reg || left_reg == 8'd0) begin
            q_job.kind = KIND_ERR;
        end else begin
            q_job.csum = pay_sum;
            if (pay_left == 8'd0) begin
                q_job.kind = KIND_PEND;
                sum_next   = '0;
                left_next  = '0;
                open_next  = 1'b0;
            end else begin
                q_job.kind = KIND_PAY;
                sum_next   = pay_sum;
                left_next  = pay_left;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            left_reg <= '0;
            open_reg <= 1'b0;
        end else if (q_push) begin
            sum_reg  <= sum_next;
            left_reg <= left_next;
            open_reg <= open_next;
        end
    end

endmodule

FILE: src/rsfb_queue.sv
// ----------------------------------------------------------------------------
// rsfb_queue
// small job fifo between front and back
// ----------------------------------------------------------------------------
module rsfb_queue
    import rsfb_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = slot_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop  ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_reg] <= push_job;
        end
    end

endmodule

FILE: src/rsfb_back.sv
// ----------------------------------------------------------------------------
// rsfb_back
// steps through each job and drives the output register
// ----------------------------------------------------------------------------
module rsfb_back
    import rsfb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  job_t       q_job,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_tx_byte,
    output logic       m_frame_end,
    output logic       m_seq_last,
    output logic       m_error
);

    job_t              job_reg;
    logic              active_reg, active_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              valid_reg, valid_next;
    logic [7:0]        byte_reg;
    logic              fend_reg, last_reg, err_reg;

    logic              out_free, emit, done;
    logic [7:0]        cur_byte;
    logic              cur_fend, cur_last, cur_err;

    // decode of the current step
    always_comb begin
        cur_byte = '0;
        cur_fend = 1'b0;
        cur_last = 1'b0;
        cur_err  = 1'b0;
        done     = 1'b0;
        unique case (job_reg.kind)
            KIND_HDR: begin
                unique case (step_reg)
                    STEP_PRE0:    cur_byte = PREAMBLE_0;
                    STEP_PRE1:    cur_byte = PREAMBLE_1;
                    STEP_PRE2:    cur_byte = PREAMBLE_2;
                    STEP_PRE3:    cur_byte = PREAMBLE_3;
                    STEP_PROTO:   cur_byte = job_reg.protocol_id;
                    STEP_DEST:    cur_byte = job_reg.destination;
                    STEP_SRC:     cur_byte = job_reg.source;
                    STEP_MSG:     cur_byte = job_reg.message_code;
                    STEP_LEN: begin
                        cur_byte = job_reg.payload_length;
                        cur_last = (job_reg.payload_length != 8'd0);
                        done     = cur_last;
                    end
                    STEP_HCSUM_H: cur_byte = job_reg.csum[15:8];
                    STEP_HCSUM_L: begin
                        cur_byte = job_reg.csum[7:0];
                        cur_fend = 1'b1;
                        cur_last = 1'b1;
                        done     = 1'b1;
                    end
                    default:      done = 1'b1;
                endcase
            end
            KIND_PAY: begin
                cur_byte = job_reg.data;
                cur_last = 1'b1;
                done     = 1'b1;
            end
            KIND_PEND: begin
                unique case (step_reg)
                    STEP_DATA:    cur_byte = job_reg.data;
                    STEP_PCSUM_H: cur_byte = job_reg.csum[15:8];
                    STEP_PCSUM_L: begin
                        cur_byte = job_reg.csum[7:0];
                        cur_fend = 1'b1;
                        cur_last = 1'b1;
                        done     = 1'b1;
                    end
                    default:      done = 1'b1;
                endcase
            end
            KIND_ERR: begin
                cur_last = 1'b1;
                cur_err  = 1'b1;
                done     = 1'b1;
            end
            default: done = 1'b1;
        endcase
    end

    assign out_free = !valid_reg || m_ready;
    assign emit     = active_reg && out_free;
    assign q_pop    = q_valid && (!active_reg || (emit && done));

    always_comb begin
        active_next = active_reg;
        step_next   = step_reg;
        if (q_pop) begin
            active_next = 1'b1;
            step_next   = '0;
        end else if (emit) begin
            active_next = !done;
            step_next   = step_reg + 1'b1;
        end
        valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            step_reg   <= '0;
            valid_reg  <= 1'b0;
        end else begin
            active_reg <= active_next;
            step_reg   <= step_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_job;
        end
        if (emit) begin
            byte_reg <= cur_byte;
            fend_reg <= cur_fend;
            last_reg <= cur_last;
            err_reg  <= cur_err;
        end
    end

    assign m_valid     = valid_reg;
    assign m_tx_byte   = byte_reg;
    assign m_frame_end = fend_reg;
    assign m_seq_last  = last_reg;
    assign m_error     = err_reg;

endmodule

FILE: src/rsfb_checker.sv
// ----------------------------------------------------------------------------
// rsfb_checker
// port-level checks of the result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "rs485_frame_builder_top_defines.svh"

module rsfb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_tx_byte,
    input logic       m_frame_end,
    input logic       m_seq_last,
    input logic       m_error
);

    // stalled beat holds
    `RSFB_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_tx_byte) && $stable(m_frame_end) && $stable(m_seq_last) && $stable(m_error), "result beat changed while stalled")

    // error beat is a lone zero byte
    `RSFB_ASSERT_NOW(a_err_shape, aclk, aresetn, m_valid && m_error, m_seq_last && !m_frame_end && (m_tx_byte == 8'h00), "malformed error beat")

    // frame end closes the item's result sequence
    `RSFB_ASSERT_NOW(a_fend_last, aclk, aresetn, m_valid && m_frame_end, m_seq_last && !m_error, "frame end without sequence end")

endmodule

bind rs485_frame_builder_top rsfb_checker u_checker (.*);

FILE: tb/sv/rs485_frame_builder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rs485_frame_builder_top_tb
// drives header and payload beats into the frame builder, predicts every
// wire byte with its own frame and checksum tracker, and checks each output
// beat in order under random stalls on both sides
// ----------------------------------------------------------------------------
module rs485_frame_builder_top_tb;
    import rsfb_pkg::*;

    localparam int  RAND_ITEMS  = 150;
    localparam int  DRAIN_CYC   = 20;
    localparam int  IDLE_PCT    = 11;
    localparam time RUN_LIMIT   = 5ms;

    // one input item, all fields present on every beat
    typedef struct packed {
        logic       command;
        logic [7:0] protocol_id;
        logic [7:0] destination;
        logic [7:0] source;
        logic [7:0] message_code;
        logic [7:0] payload_length;
        logic [7:0] payload_byte;
    } frame_item_t;

    // one byte on the wire with its flags
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_end;
        logic       seq_last;
        logic       error;
    } wire_beat_t;

    // directed row: item plus an optional hand-written expected beat
    typedef struct packed {
        frame_item_t item;
        logic        typed;
        wire_beat_t  beat;
    } dir_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_command = 1'b0;
    logic [7:0] s_protocol_id = 8'h00;
    logic [7:0] s_destination = 8'h00;
    logic [7:0] s_source = 8'h00;
    logic [7:0] s_message_code = 8'h00;
    logic [7:0] s_payload_length = 8'h00;
    logic [7:0] s_payload_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_tx_byte;
    logic       m_frame_end;
    logic       m_seq_last;
    logic       m_error;

    // while set, neither side idles
    logic calm = 1'b0;

    // predictor state: running checksum, payload bytes still due, frame open
    logic [15:0] csum_acc = 16'h0000;
    logic [7:0]  bytes_due = 8'h00;
    logic        frame_live = 1'b0;

    wire_beat_t  pred_q[$];       // beats of the item just accepted
    wire_beat_t  wire_exp_q[$];   // beats still owed by the block
    dir_row_t    dir_rows[$];
    int          mismatches = 0;

    always #5 aclk = ~aclk;

    rs485_frame_builder_top i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_protocol_id    (s_protocol_id),
        .s_destination    (s_destination),
        .s_source         (s_source),
        .s_message_code   (s_message_code),
        .s_payload_length (s_payload_length),
        .s_payload_byte   (s_payload_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_tx_byte        (m_tx_byte),
        .m_frame_end      (m_frame_end),
        .m_seq_last       (m_seq_last),
        .m_error          (m_error)
    );

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    function automatic void add_beat(input logic [7:0] b, input logic fe,
                                     input logic sl, input logic er);
        wire_beat_t w;
        w.tx_byte   = b;
        w.frame_end = fe;
        w.seq_last  = sl;
        w.error     = er;
        pred_q.push_back(w);
    endfunction

    // two checksum bytes, high first, then the frame is closed
    function automatic void close_frame_bytes();
        add_beat(csum_acc[15:8], 1'b0, 1'b0, 1'b0);
        add_beat(csum_acc[7:0], 1'b1, 1'b1, 1'b0);
        csum_acc   = 16'h0000;
        bytes_due  = 8'h00;
        frame_live = 1'b0;
    endfunction

    // wire bytes caused by one item, left in pred_q
    function automatic void predict_wire_bytes(input frame_item_t it);
        logic [39:0] hdr;
        logic [7:0]  b;
        pred_q.delete();
        if (it.command == CMD_HEADER) begin
            // a header always restarts, an open frame is simply dropped
            hdr = {it.protocol_id, it.destination, it.source, it.message_code,
                   it.payload_length};
            add_beat(PREAMBLE_0, 1'b0, 1'b0, 1'b0);
            add_beat(PREAMBLE_1, 1'b0, 1'b0, 1'b0);
            add_beat(PREAMBLE_2, 1'b0, 1'b0, 1'b0);
            add_beat(PREAMBLE_3, 1'b0, 1'b0, 1'b0);
            csum_acc = {8'h00, PREAMBLE_3};
            for (int i = 0; i < 5; i++) begin
                b = hdr[39 - 8*i -: 8];
                csum_acc = csum_acc + {8'h00, b};
                // length byte ends the item unless the frame is empty
                add_beat(b, 1'b0, (i == 4) && (it.payload_length != 8'h00), 1'b0);
            end
            bytes_due  = it.payload_length;
            frame_live = 1'b1;
            if (bytes_due == 8'h00) begin
                close_frame_bytes();
            end
        end else if (!frame_live || bytes_due == 8'h00) begin
            // stray payload byte, dropped with an error beat
            add_beat(8'h00, 1'b0, 1'b1, 1'b1);
        end else begin
            csum_acc  = csum_acc + {8'h00, it.payload_byte};
            bytes_due = bytes_due - 8'd1;
            if (bytes_due == 8'h00) begin
                add_beat(it.payload_byte, 1'b0, 1'b0, 1'b0);
                close_frame_bytes();
            end else begin
                add_beat(it.payload_byte, 1'b0, 1'b1, 1'b0);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------------

    function automatic frame_item_t header_item(input logic [7:0] p, input logic [7:0] d,
                                                input logic [7:0] s, input logic [7:0] m,
                                                input logic [7:0] len);
        frame_item_t it;
        it.command        = CMD_HEADER;
        it.protocol_id    = p;
        it.destination    = d;
        it.source         = s;
        it.message_code   = m;
        it.payload_length = len;
        it.payload_byte   = 8'($urandom);   // ignored on headers
        return it;
    endfunction

    function automatic frame_item_t payload_item(input logic [7:0] b);
        frame_item_t it;
        it                = frame_item_t'($urandom);   // header fields ignored
        it.command        = CMD_PAYLOAD;
        it.payload_byte   = b;
        return it;
    endfunction

    function automatic void dir_hdr(input logic [7:0] p, input logic [7:0] d,
                                    input logic [7:0] s, input logic [7:0] m,
                                    input logic [7:0] len);
        dir_row_t r;
        r.item  = header_item(p, d, s, m, len);
        r.typed = 1'b0;
        r.beat  = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void dir_pay(input logic [7:0] b, input logic typed,
                                    input logic [7:0] tx, input logic fe,
                                    input logic sl, input logic er);
        dir_row_t r;
        r.item           = payload_item(b);
        r.typed          = typed;
        r.beat.tx_byte   = tx;
        r.beat.frame_end = fe;
        r.beat.seq_last  = sl;
        r.beat.error     = er;
        dir_rows.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // present one item, hold it until taken, then book its expected beats
    task automatic send_item(input frame_item_t it, input logic typed,
                             input wire_beat_t typed_beat);
        // random idle cycles before the beat, valid dropped once per cycle
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_command        <= it.command;
        s_protocol_id    <= it.protocol_id;
        s_destination    <= it.destination;
        s_source         <= it.source;
        s_message_code   <= it.message_code;
        s_payload_length <= it.payload_length;
        s_payload_byte   <= it.payload_byte;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // accepted at this edge
        predict_wire_bytes(it);
        if (typed) begin
            wire_exp_q.push_back(typed_beat);
        end else begin
            foreach (pred_q[i]) wire_exp_q.push_back(pred_q[i]);
        end
    endtask

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------

    task automatic note_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        if (mismatches < 40) begin
            $display("%0t mismatch %s: got %02h want %02h", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    // downstream stalls at random, never while calm
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // compare each taken result beat with the oldest expectation
    always @(posedge aclk) begin
        wire_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (wire_exp_q.size() == 0) begin
                note_mismatch("beat with nothing owed, tx_byte", m_tx_byte, 8'h00);
            end else begin
                want = wire_exp_q.pop_front();
                if (m_tx_byte !== want.tx_byte)
                    note_mismatch("tx_byte", m_tx_byte, want.tx_byte);
                if (m_frame_end !== want.frame_end)
                    note_mismatch("frame_end", 8'(m_frame_end), 8'(want.frame_end));
                if (m_seq_last !== want.seq_last)
                    note_mismatch("seq_last", 8'(m_seq_last), 8'(want.seq_last));
                if (m_error !== want.error)
                    note_mismatch("error", 8'(m_error), 8'(want.error));
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    initial begin
        int          rand_items;
        int          kind;
        int          len;
        int          cut;
        frame_item_t it;

        rand_items = 0;

        // directed rows; typed beats only where the answer is obvious
        dir_pay(8'h3C, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1);   // payload right after reset
        dir_hdr(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);      // all-zero empty frame
        dir_pay(8'hFF, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1);   // payload after a closed frame
        dir_hdr(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01);      // all-ones header, one byte
        dir_pay(8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);   // last byte plus checksum
        dir_hdr(8'h12, 8'h34, 8'h56, 8'h78, 8'h03);
        dir_pay(8'h00, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0);
        dir_pay(8'hAA, 1'b1, 8'hAA, 1'b0, 1'b1, 1'b0);
        dir_pay(8'h55, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
        dir_hdr(8'hAB, 8'hCD, 8'hEF, 8'h01, 8'h04);
        dir_pay(8'h80, 1'b1, 8'h80, 1'b0, 1'b1, 1'b0);
        dir_hdr(8'h01, 8'h02, 8'h03, 8'h04, 8'h02);      // restart while a frame is open
        dir_pay(8'h7F, 1'b1, 8'h7F, 1'b0, 1'b1, 1'b0);
        dir_pay(8'h01, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
        dir_pay(8'h01, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1);
        dir_hdr(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);      // longest length
        dir_pay(8'hFF, 1'b1, 8'hFF, 1'b0, 1'b1, 1'b0);
        dir_hdr(8'h5A, 8'hA5, 8'hC3, 8'h3C, 8'h00);      // empty frame abandons the long one
        dir_pay(8'h00, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1);
        dir_hdr(8'h80, 8'h40, 8'h20, 8'h10, 8'h80);
        dir_pay(8'h01, 1'b1, 8'h01, 1'b0, 1'b1, 1'b0);

        // reset
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].beat);
        end

        // hold off until the block has delivered everything
        s_valid <= 1'b0;
        @(posedge aclk);
        while (wire_exp_q.size() != 0) @(posedge aclk);

        // full-length frame of all-ones bytes, the checksum wraps past 16 bits
        send_item(header_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0, '0);
        for (int i = 0; i < 255; i++) begin
            send_item(payload_item(8'hFF), 1'b0, '0);
        end

        // random traffic, mostly well-formed frames
        while (rand_items < RAND_ITEMS) begin
            // long stretch with no idling on either side
            calm <= (rand_items >= 40) && (rand_items < 100);
            kind = $urandom_range(99);
            if (kind < 70) begin
                // complete frame, mostly short
                len = $urandom_range(99);
                if (len < 60)      len = $urandom_range(4);
                else if (len < 90) len = $urandom_range(16, 5);
                else               len = $urandom_range(40, 17);
                it = header_item(8'($urandom), 8'($urandom), 8'($urandom),
                                 8'($urandom), 8'(len));
                send_item(it, 1'b0, '0);
                rand_items++;
                for (int i = 0; i < len; i++) begin
                    send_item(payload_item(8'($urandom)), 1'b0, '0);
                    rand_items++;
                end
            end else if (kind < 82) begin
                // frame cut short, any length, abandoned by whatever comes next
                len = $urandom_range(255, 1);
                cut = $urandom_range((len - 1 < 6) ? len - 1 : 6);
                it = header_item(8'($urandom), 8'($urandom), 8'($urandom),
                                 8'($urandom), 8'(len));
                send_item(it, 1'b0, '0);
                rand_items++;
                for (int i = 0; i < cut; i++) begin
                    send_item(payload_item(8'($urandom)), 1'b0, '0);
                    rand_items++;
                end
            end else if (kind < 94) begin
                // stray payload bytes
                cut = $urandom_range(3, 1);
                for (int i = 0; i < cut; i++) begin
                    send_item(payload_item(8'($urandom)), 1'b0, '0);
                    rand_items++;
                end
            end else begin
                // fully random item
                it = frame_item_t'({$urandom, $urandom});
                send_item(it, 1'b0, '0);
                rand_items++;
            end
        end
        calm <= 1'b0;
        s_valid <= 1'b0;

        // drain, then watch a little longer for extra beats
        @(posedge aclk);
        while (wire_exp_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // hung-run guard
    initial begin
        #(RUN_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
